// ----- rtl/tfr_pkg.sv -----
// ----------------------------------------------------------------------------
// tfr_pkg
// shared constants, codes and controller/datapath interface types for the
// tag frame rewriter
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int MAX_TEXT     = 32;
  localparam int HEADER_BYTES = 10;

  localparam int TEXT_AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int TLEN_W  = $clog2(MAX_TEXT + 1);

  // configuration port
  localparam int CFG_AW    = 3;
  localparam int CFG_IDX_W = CFG_AW - 2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_SELECT = '0;
  localparam logic [2:0] TAG_SELECT_RESET = 3'd1;

  // input item kinds
  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_APPEND = 2'd1;
  localparam logic [1:0] FN_FILE   = 2'd2;

  // frame selector codes
  localparam logic [2:0] TAG_TPE1 = 3'd0;
  localparam logic [2:0] TAG_TIT2 = 3'd1;
  localparam logic [2:0] TAG_TALB = 3'd2;
  localparam logic [2:0] TAG_TYER = 3'd3;
  localparam logic [2:0] TAG_TCON = 3'd4;
  localparam logic [2:0] TAG_COMM = 3'd5;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FOUND = 2'd1,
    EV_STOP  = 2'd2
  } event_t;

  typedef enum logic [1:0] {
    SRC_BYTE = 2'd0,
    SRC_SIZE = 2'd1,
    SRC_STOP = 2'd2,
    SRC_TEXT = 2'd3
  } src_sel_t;

  typedef struct packed {
    logic hdr_done;
    logic id_first;
    logic id_last;
    logic size_last;
    logic flags_last;
    logic is_letter;
    logic id_match;
    logic is_target;
    logic frame_le1;
    logic dleft_zero;
    logic data_last;
    logic text_empty;
    logic burst_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic     out_load;
    src_sel_t out_sel;
    event_t   out_event;
    logic     out_last;
    logic     fc_clr;
    logic     fc_inc;
    logic     id_shift;
    logic     size_clr;
    logic     size_shift;
    logic     tgt_load;
    logic     dleft_load;
    logic     dleft_dec;
    logic     parser_clr;
    logic     text_clr;
    logic     text_push;
    logic     burst_start;
    logic     burst_step;
  } cmd_t;

  // four-character frame id match against the three stored bytes plus the new one
  function automatic logic id_match(input logic [2:0] sel, input logic [23:0] id3,
                                     input logic [7:0] b);
    logic [31:0] ref_id;
    logic        ok;
    ok = 1'b1;
    case (sel)
      TAG_TPE1: ref_id = "TPE1";
      TAG_TIT2: ref_id = "TIT2";
      TAG_TALB: ref_id = "TALB";
      TAG_TYER: ref_id = "TYER";
      TAG_TCON: ref_id = "TCON";
      TAG_COMM: ref_id = "COMM";
      default: begin
        ref_id = '0;
        ok     = 1'b0;
      end
    endcase
    return ok && ({id3, b} == ref_id);
  endfunction

endpackage

// ----- rtl/tag_frame_rewriter_unit.sv -----
// ----------------------------------------------------------------------------
// tag_frame_rewriter_unit
// rewrites one text frame of a tagged audio byte stream
// ----------------------------------------------------------------------------
// A file byte gives at most one result byte through the output register,
// and text appends and clears give none. The one exception is the last flag
// byte of the selected frame, which is followed by the stored replacement
// text, one byte per cycle out of the text ram (one read port) while the
// output register has room; input is held off until the text is through.
// Input is also held while the output register is full and not being taken.
// The selected frame's size field is replaced by text length + 1; the header
// total size is passed through unchanged.
// ----------------------------------------------------------------------------
module tag_frame_rewriter_unit
  import tfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input item stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [7:0] in_byte
  input  logic [1:0]        in_tuser,     // [1:0] func
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,    // [7:0] out_byte
  output logic [2:0]        out_tuser,    // [0] has_byte, [2:1] event_res
  output logic              out_tlast,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  status_t              st;
  cmd_t                 cmd;
  logic [2:0]           tag_sel_r, tag_sel_nxt;
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  event_t               out_event;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign tag_sel_nxt = (cfg_wr && (cfg_idx == REG_TAG_SELECT)) ? cfg_pwdata[2:0]
                                                               : tag_sel_r;
  assign cfg_prdata  = (cfg_idx == REG_TAG_SELECT) ? {29'd0, tag_sel_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_sel_r <= TAG_SELECT_RESET;
    end else begin
      tag_sel_r <= tag_sel_nxt;
    end
  end

  tfr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_func (in_tuser),
    .st      (st),
    .in_ready(in_tready),
    .cmd     (cmd)
  );

  tfr_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .tag_sel  (tag_sel_r),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_has  (out_tuser[0]),
    .out_event(out_event),
    .out_last (out_tlast)
  );

  assign out_tuser[2:1] = out_event;

endmodule

// ----- rtl/tfr_ram.sv -----
// ----------------------------------------------------------------------------
// tfr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfr_ctrl
// parser state machine: walks header, frame fields and the text burst and
// drives the datapath through a command struct
// ----------------------------------------------------------------------------
module tfr_ctrl
  import tfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  input  status_t     st,
  output logic        in_ready,
  output cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_HEADER,
    S_ID,
    S_SIZE,
    S_FLAGS,
    S_BURST,
    S_DATA,
    S_PASS,
    S_STOP
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r != S_BURST) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.out_last = 1'b1;
    state_nxt    = state_r;
    if (state_r == S_BURST) begin
      if (st.out_free) begin
        cmd.out_load   = 1'b1;
        cmd.out_sel    = SRC_TEXT;
        cmd.out_last   = st.burst_last;
        cmd.burst_step = 1'b1;
        if (st.burst_last) begin
          state_nxt = st.dleft_zero ? S_PASS : S_DATA;
        end
      end
    end else if (accept) begin
      case (in_func)
        FN_CLEAR: begin
          cmd.parser_clr = 1'b1;
          cmd.text_clr   = 1'b1;
          state_nxt      = S_HEADER;
        end
        FN_APPEND: begin
          cmd.text_push = 1'b1;
        end
        FN_FILE: begin
          case (state_r)
            S_HEADER: begin
              cmd.out_load = 1'b1;
              cmd.fc_inc   = 1'b1;
              if (st.hdr_done) begin
                cmd.fc_clr = 1'b1;
                state_nxt  = S_ID;
              end
            end
            S_ID: begin
              cmd.out_load = 1'b1;
              if (st.id_first && !st.is_letter) begin
                cmd.out_sel   = SRC_STOP;
                cmd.out_event = EV_STOP;
                state_nxt     = S_STOP;
              end else if (!st.id_last) begin
                cmd.id_shift = 1'b1;
                cmd.fc_inc   = 1'b1;
              end else begin
                cmd.out_event = st.id_match ? EV_FOUND : EV_NONE;
                cmd.tgt_load  = 1'b1;
                cmd.fc_clr    = 1'b1;
                cmd.size_clr  = 1'b1;
                state_nxt     = S_SIZE;
              end
            end
            S_SIZE: begin
              cmd.out_load   = 1'b1;
              cmd.out_sel    = st.is_target ? SRC_SIZE : SRC_BYTE;
              cmd.size_shift = 1'b1;
              cmd.fc_inc     = 1'b1;
              if (st.size_last) begin
                cmd.fc_clr = 1'b1;
                state_nxt  = S_FLAGS;
              end
            end
            S_FLAGS: begin
              cmd.out_load = 1'b1;
              cmd.fc_inc   = 1'b1;
              if (st.flags_last) begin
                cmd.fc_clr     = 1'b1;
                cmd.dleft_load = 1'b1;
                if (st.is_target && !st.text_empty) begin
                  // text follows the last flag byte
                  cmd.out_last    = 1'b0;
                  cmd.burst_start = 1'b1;
                  state_nxt       = S_BURST;
                end else if (st.frame_le1) begin
                  state_nxt = st.is_target ? S_PASS : S_ID;
                end else begin
                  state_nxt = S_DATA;
                end
              end
            end
            S_DATA: begin
              cmd.out_load  = !st.is_target;
              cmd.dleft_dec = 1'b1;
              if (st.data_last) begin
                cmd.fc_clr = 1'b1;
                state_nxt  = st.is_target ? S_PASS : S_ID;
              end
            end
            S_PASS: begin
              cmd.out_load = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BURST) |-> !in_ready)
    else $error("input taken during text burst");

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> st.out_free)
    else $error("output register overwritten");

  a_burst_entered: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.burst_start |=> (state_r == S_BURST))
    else $error("burst start without burst state");

endmodule

// ----- rtl/tfr_dp.sv -----
// ----------------------------------------------------------------------------
// tfr_dp
// parser datapath: field counter, id/size/length registers, text store and
// output register
// ----------------------------------------------------------------------------
module tfr_dp
  import tfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic [2:0]  tag_sel,
  input  cmd_t        cmd,
  output status_t     st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has,
  output event_t      out_event,
  output logic        out_last
);

  logic [3:0]        fc_r, fc_nxt;
  logic [23:0]       id_r, id_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       dleft_r, dleft_nxt;
  logic              tgt_r, tgt_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic [TLEN_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_has_r, out_has_nxt;
  event_t            out_event_r;
  logic              out_last_r;
  logic              text_we;
  logic [7:0]        text_rdata;
  logic [31:0]       new_size;
  logic [7:0]        size_byte;

  tfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_TEXT)
  ) u_text (
    .clk  (clk),
    .we   (text_we),
    .waddr(tlen_r[TEXT_AW-1:0]),
    .wdata(in_byte),
    .raddr(cnt_nxt[TEXT_AW-1:0]),
    .rdata(text_rdata)
  );

  assign text_we   = cmd.text_push && (tlen_r < TLEN_W'(MAX_TEXT));
  assign new_size  = 32'(tlen_r) + 32'd1;
  // big-endian byte of the replacement size picked by the field counter
  assign size_byte = 8'(new_size >> {(2'd3 - fc_r[1:0]), 3'b000});

  always_comb begin
    st.hdr_done   = (fc_r == 4'(HEADER_BYTES - 1));
    st.id_first   = (fc_r == 4'd0);
    st.id_last    = (fc_r == 4'd3);
    st.size_last  = (fc_r == 4'd3);
    st.flags_last = (fc_r == 4'd2);
    st.is_letter  = ((in_byte >= 8'h41) && (in_byte <= 8'h5a)) ||
                    ((in_byte >= 8'h61) && (in_byte <= 8'h7a));
    st.id_match   = id_match(tag_sel, id_r, in_byte);
    st.is_target  = tgt_r;
    st.frame_le1  = (size_r <= 32'd1);
    st.dleft_zero = (dleft_r == 32'd0);
    st.data_last  = (dleft_r == 32'd1);
    st.text_empty = (tlen_r == '0);
    st.burst_last = (cnt_r == (tlen_r - TLEN_W'(1)));
    st.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    fc_nxt    = fc_r;
    id_nxt    = id_r;
    size_nxt  = size_r;
    dleft_nxt = dleft_r;
    tgt_nxt   = tgt_r;
    tlen_nxt  = tlen_r;
    cnt_nxt   = cnt_r;
    if (cmd.fc_clr) begin
      fc_nxt = '0;
    end else if (cmd.fc_inc) begin
      fc_nxt = fc_r + 4'd1;
    end
    if (cmd.id_shift) begin
      id_nxt = {id_r[15:0], in_byte};
    end
    if (cmd.size_clr) begin
      size_nxt = '0;
    end else if (cmd.size_shift) begin
      size_nxt = {size_r[23:0], in_byte};
    end
    if (cmd.tgt_load) begin
      tgt_nxt = st.id_match;
    end
    if (cmd.dleft_load) begin
      dleft_nxt = (size_r == 32'd0) ? 32'd0 : size_r - 32'd1;
    end else if (cmd.dleft_dec) begin
      dleft_nxt = dleft_r - 32'd1;
    end
    if (cmd.text_clr) begin
      tlen_nxt = '0;
    end else if (text_we) begin
      tlen_nxt = tlen_r + TLEN_W'(1);
    end
    if (cmd.burst_start) begin
      cnt_nxt = '0;
    end else if (cmd.burst_step) begin
      cnt_nxt = cnt_r + TLEN_W'(1);
    end
    if (cmd.parser_clr) begin
      fc_nxt    = '0;
      id_nxt    = '0;
      size_nxt  = '0;
      dleft_nxt = '0;
      tgt_nxt   = 1'b0;
    end
  end

  always_comb begin
    case (cmd.out_sel)
      SRC_BYTE: begin
        out_byte_nxt = in_byte;
        out_has_nxt  = 1'b1;
      end
      SRC_SIZE: begin
        out_byte_nxt = size_byte;
        out_has_nxt  = 1'b1;
      end
      SRC_STOP: begin
        out_byte_nxt = 8'd0;
        out_has_nxt  = 1'b0;
      end
      SRC_TEXT: begin
        out_byte_nxt = text_rdata;
        out_has_nxt  = 1'b1;
      end
      default: begin
        out_byte_nxt = 8'd0;
        out_has_nxt  = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r        <= '0;
      id_r        <= '0;
      size_r      <= '0;
      dleft_r     <= '0;
      tgt_r       <= 1'b0;
      tlen_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fc_r        <= fc_nxt;
      id_r        <= id_nxt;
      size_r      <= size_nxt;
      dleft_r     <= dleft_nxt;
      tgt_r       <= tgt_nxt;
      tlen_r      <= tlen_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r  <= out_byte_nxt;
      out_has_r   <= out_has_nxt;
      out_event_r <= cmd.out_event;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_has   = out_has_r;
  assign out_event = out_event_r;
  assign out_last  = out_last_r;

  a_text_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= TLEN_W'(MAX_TEXT))
    else $error("text length beyond capacity");

  a_burst_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.burst_step |-> (cnt_r < tlen_r))
    else $error("text read past stored length");

  a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dleft_dec |-> (dleft_r != 32'd0))
    else $error("data count underflow");

endmodule

// ----- tb/tag_frame_rewriter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// tag_frame_rewriter_unit_tb
// Self-checking bench for the tag frame rewriter. Whole tag streams are
// built with random content: a text load, a 10-byte header and a run of
// frames, some of them the selected one, some with a bad ID, some cut short.
// Each accepted item is run through a behavioural copy of the rewriter and
// the results it gives are queued, then compared in order against the result
// stream. The sender works in bursts and the receiver stalls in changing
// patterns. The frame selector is rewritten over the APB port between runs.
// ----------------------------------------------------------------------------
module tag_frame_rewriter_unit_tb
  import tfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED   = 2'd3;
  localparam logic [2:0] SEL_SPARE_6 = 3'd6;
  localparam logic [2:0] SEL_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 10;
  localparam int RUN_ITEMS     = 10;

  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] b;
  } tag_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       has;
    event_t     ev;
    logic       last;
  } stream_out_t;

  typedef enum logic [2:0] {
    ST_HEADER, ST_ID, ST_SIZE, ST_FLAGS, ST_DATA, ST_PASS, ST_STOP
  } parse_phase_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_PERIODIC
  } ready_mode_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;
  logic [1:0]        in_tuser    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [7:0]        out_tdata;
  logic [2:0]        out_tuser;
  logic              out_tlast;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  tag_item_t   file_q[$];
  stream_out_t rewritten_q[$];
  stream_out_t step_out[$];

  int items_queued = 0;
  int items_taken  = 0;
  int phase_items  = 0;
  int error_count  = 0;
  int cycle_count  = 0;
  int burst_left   = 1;
  int gap_left     = 0;
  int hold_cnt     = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  // behavioural copy of the rewriter state
  logic [2:0]   sel_now   = TAG_SELECT_RESET;
  parse_phase_t parse_ph  = ST_HEADER;
  int           field_cnt = 0;
  logic [23:0]  id_hist   = '0;
  logic [31:0]  frame_len = '0;
  logic [31:0]  data_rem  = '0;
  logic         on_target = 1'b0;
  logic [7:0]   text_buf [0:MAX_TEXT-1];
  int           text_cnt  = 0;

  tag_frame_rewriter_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] frame_id_of(input logic [2:0] s);
    case (s)
      TAG_TPE1: return "TPE1";
      TAG_TIT2: return "TIT2";
      TAG_TALB: return "TALB";
      TAG_TYER: return "TYER";
      TAG_TCON: return "TCON";
      TAG_COMM: return "COMM";
      default:  return 32'h0;
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic has, input event_t ev);
    stream_out_t r;
    r.b    = b;
    r.has  = has;
    r.ev   = ev;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  // advance the copy by one item and queue the stream bytes it gives
  function automatic void rewrite_item(input logic [1:0] fn, input logic [7:0] b);
    stream_out_t r;
    logic [31:0] new_len;
    int          k;
    step_out.delete();
    case (fn)
      FN_CLEAR: begin
        text_cnt  = 0;
        parse_ph  = ST_HEADER;
        field_cnt = 0;
        id_hist   = '0;
        frame_len = '0;
        data_rem  = '0;
        on_target = 1'b0;
      end
      FN_APPEND: begin
        if (text_cnt < MAX_TEXT) begin
          text_buf[text_cnt] = b;
          text_cnt++;
        end
      end
      FN_FILE: begin
        case (parse_ph)
          ST_HEADER: begin
            emit(b, 1'b1, EV_NONE);
            field_cnt++;
            if (field_cnt >= HEADER_BYTES) begin
              parse_ph  = ST_ID;
              field_cnt = 0;
            end
          end
          ST_ID: begin
            if (field_cnt == 0 && !is_letter(b)) begin
              parse_ph = ST_STOP;
              emit(8'h00, 1'b0, EV_STOP);
            end else if (field_cnt < 3) begin
              id_hist = {id_hist[15:0], b};
              emit(b, 1'b1, EV_NONE);
              field_cnt++;
            end else begin
              on_target = (sel_now <= TAG_COMM) && ({id_hist, b} == frame_id_of(sel_now));
              emit(b, 1'b1, on_target ? EV_FOUND : EV_NONE);
              parse_ph  = ST_SIZE;
              field_cnt = 0;
              frame_len = '0;
            end
          end
          ST_SIZE: begin
            frame_len = {frame_len[23:0], b};
            new_len   = text_cnt + 1;
            // selected frame gets the text length plus one, big-endian
            if (on_target) emit(new_len[8*(3-field_cnt) +: 8], 1'b1, EV_NONE);
            else emit(b, 1'b1, EV_NONE);
            field_cnt++;
            if (field_cnt >= 4) begin
              parse_ph  = ST_FLAGS;
              field_cnt = 0;
            end
          end
          ST_FLAGS: begin
            emit(b, 1'b1, EV_NONE);
            field_cnt++;
            if (field_cnt >= 3) begin
              field_cnt = 0;
              data_rem  = (frame_len != 0) ? frame_len - 1 : 32'd0;
              if (on_target)
                for (k = 0; k < text_cnt; k++) emit(text_buf[k], 1'b1, EV_NONE);
              if (data_rem != 0) parse_ph = ST_DATA;
              else parse_ph = on_target ? ST_PASS : ST_ID;
            end
          end
          ST_DATA: begin
            if (!on_target) emit(b, 1'b1, EV_NONE);
            data_rem--;
            if (data_rem == 0) begin
              parse_ph  = on_target ? ST_PASS : ST_ID;
              field_cnt = 0;
            end
          end
          ST_PASS: emit(b, 1'b1, EV_NONE);
          default: ;
        endcase
      end
      default: ;
    endcase
    foreach (step_out[i]) begin
      r      = step_out[i];
      r.last = (i == step_out.size() - 1);
      rewritten_q.push_back(r);
    end
  endfunction

  task automatic add_item(input logic [1:0] fn, input logic [7:0] b);
    tag_item_t it;
    it.fn = fn;
    it.b  = b;
    file_q.push_back(it);
    items_queued++;
    if (fn != FN_UNUSED) phase_items++;
  endtask

  // one tag stream: text load, header, frames, trailing bytes
  task automatic queue_tag_sequence(input logic [2:0] s);
    int          n_text, n_frames, n_data, k, f;
    logic [31:0] id_word, flen;
    logic [7:0]  b;
    add_item(FN_CLEAR, 8'($urandom));
    k = $urandom_range(0, 9);
    n_text = (k == 0) ? 0 : (k == 1) ? $urandom_range(MAX_TEXT, MAX_TEXT + 4)
                                     : $urandom_range(1, 8);
    for (k = 0; k < n_text; k++) add_item(FN_APPEND, 8'($urandom));
    if ($urandom_range(0, 7) == 0) add_item(FN_UNUSED, 8'($urandom));
    // header cut short
    if ($urandom_range(0, 11) == 0) begin
      n_data = $urandom_range(1, HEADER_BYTES - 1);
      for (k = 0; k < n_data; k++) add_item(FN_FILE, 8'($urandom));
      return;
    end
    for (k = 0; k < HEADER_BYTES; k++) add_item(FN_FILE, 8'($urandom));
    n_frames = $urandom_range(1, 4);
    for (f = 0; f < n_frames; f++) begin
      k = $urandom_range(0, 9);
      if (k <= 3 && s <= TAG_COMM) begin
        id_word = frame_id_of(s);
      end else if (k <= 6) begin
        id_word = frame_id_of(3'($urandom_range(0, 5)));
      end else if (k <= 8) begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5a))
                                 : 8'($urandom_range(8'h61, 8'h7a));
        id_word = {b, 24'($urandom)};
      end else begin
        // non-letter first byte, the neighbours of the letter ranges favoured
        case ($urandom_range(0, 5))
          0: b = 8'h40;
          1: b = 8'h5b;
          2: b = 8'h60;
          3: b = 8'h7b;
          default: begin
            do b = 8'($urandom); while (is_letter(b));
          end
        endcase
        id_word = {b, 24'($urandom)};
      end
      for (k = 3; k >= 0; k--) add_item(FN_FILE, id_word[8*k +: 8]);
      if (!is_letter(id_word[31:24])) begin
        n_data = $urandom_range(1, 3);
        for (k = 0; k < n_data; k++) add_item(FN_FILE, 8'($urandom));
        return;
      end
      flen = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
      for (k = 3; k >= 0; k--) add_item(FN_FILE, flen[8*k +: 8]);
      for (k = 0; k < 3; k++) add_item(FN_FILE, 8'($urandom));
      // oversized frame: send a little of it and leave the rest for the next clear
      if (flen > 6) begin
        n_data = $urandom_range(1, 4);
        for (k = 0; k < n_data; k++) add_item(FN_FILE, 8'($urandom));
        return;
      end
      n_data = (flen == 0) ? 0 : int'(flen) - 1;
      for (k = 0; k < n_data; k++) add_item(FN_FILE, 8'($urandom));
      if ($urandom_range(0, 7) == 0) add_item(FN_APPEND, 8'($urandom));
    end
    n_data = $urandom_range(0, 4);
    for (k = 0; k < n_data; k++) add_item(FN_FILE, 8'($urandom));
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued || rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tag_select(input logic [2:0] s);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_TAG_SELECT, 2'b00};
    cfg_pwdata  <= {29'd0, s};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sel_now = s;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata[2:0] !== s) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("tag_select readback: expected %0d got %0d", s, cfg_prdata[2:0]);
    end
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // sender: bursts of items with gaps between them
  always @(posedge clk) begin : drive_items
    tag_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rewrite_item(in_tuser, in_tdata);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (file_q.size() > 0) begin
          nxt = file_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.fn;
          in_tdata  <= nxt.b;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, redrawn at random when its hold counter runs out
  always @(posedge clk) begin : ready_pattern
    if (hold_cnt == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      hold_cnt   <= $urandom_range(16, 96);
    end else begin
      hold_cnt <= hold_cnt - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_tready <= 1'b1;
      RDY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
      RDY_COIN:   out_tready <= ($urandom_range(0, 1) != 0);
      default:    out_tready <= (hold_cnt[1:0] == 2'd0);
    endcase
  end

  always @(posedge clk) begin : check_results
    stream_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (rewritten_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected item: byte %h has %b ev %0d last %b",
                   out_tdata, out_tuser[0], out_tuser[2:1], out_tlast);
      end else begin
        want = rewritten_q.pop_front();
        if (out_tdata !== want.b || out_tuser[0] !== want.has ||
            out_tuser[2:1] !== want.ev || out_tlast !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected %h has %b ev %0d last %b, got %h has %b ev %0d last %b",
                     want.b, want.has, want.ev, want.last,
                     out_tdata, out_tuser[0], out_tuser[2:1], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL tag_frame_rewriter_unit");
      $finish;
    end
  end

  initial begin : run_test
    logic [79:0] hdr;
    logic [31:0] id_word;
    logic [2:0]  sel_plan [0:7];
    int          k;
    sel_plan = '{TAG_TPE1, TAG_COMM, SEL_SPARE_7, TAG_TYER,
                 TAG_TALB, TAG_TCON, SEL_SPARE_6, TAG_TIT2};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: selector still at its reset value (TIT2)
    add_item(FN_UNUSED, 8'hff);
    add_item(FN_CLEAR, 8'h00);
    add_item(FN_APPEND, 8'h00);
    add_item(FN_APPEND, 8'hff);
    hdr = 80'h49_44_33_03_00_00_00_00_7f_ff;
    for (k = 9; k >= 0; k--) add_item(FN_FILE, hdr[8*k +: 8]);
    id_word = frame_id_of(TAG_TIT2);
    for (k = 3; k >= 0; k--) add_item(FN_FILE, id_word[8*k +: 8]);
    // zero size, then flags, then the text burst
    for (k = 0; k < 4; k++) add_item(FN_FILE, 8'h00);
    add_item(FN_FILE, 8'h00);
    add_item(FN_FILE, 8'h80);
    add_item(FN_FILE, 8'h03);
    // after the selected frame everything passes
    add_item(FN_FILE, 8'hff);
    add_item(FN_FILE, 8'h00);
    wait_drained();

    foreach (sel_plan[p]) begin
      write_tag_select(sel_plan[p]);
      phase_items = 0;
      while (phase_items < RUN_ITEMS) queue_tag_sequence(sel_plan[p]);
      wait_drained();
    end

    if (error_count == 0 && rewritten_q.size() == 0) begin
      $display("PASS tag_frame_rewriter_unit");
    end else begin
      $display("FAIL tag_frame_rewriter_unit");
    end
    $finish;
  end

endmodule
